FILE: src/nmv_pkg.sv
// Package for the nested tag markup validator.
// Holds character codes, default sizes, the CDATA opener table and the
// stack command/status structs. No dependencies.
`default_nettype none

package nmv_pkg;

    localparam int NMV_NAME_MAX    = 9;
    localparam int NMV_STACK_DEPTH = 64;

    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_Z      = 8'h5A;

    localparam logic [2:0] CDATA_LEN = 3'd7;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } stk_cmd_t;

    typedef struct packed {
        logic empty;
        logic single;
        logic full;
    } stk_stat_t;

    // "[CDATA[" one character per index
    function automatic logic [7:0] cdata_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h5B;
            3'd1:    ch = 8'h43;
            3'd2:    ch = 8'h44;
            3'd3:    ch = 8'h41;
            3'd4:    ch = 8'h54;
            3'd5:    ch = 8'h41;
            3'd6:    ch = 8'h5B;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

FILE: src/nmv_tag_stack.sv
// Tag name stack: top entry in a register, the rest in a synchronous RAM.
// Uses nmv_pkg for command and status structs.
`default_nettype none

module nmv_tag_stack
    import nmv_pkg::*;
#(
    parameter int ENTRY_W     = 49,
    parameter int STACK_DEPTH = NMV_STACK_DEPTH
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire stk_cmd_t           cmd,
    input  wire logic [ENTRY_W-1:0] push_entry,
    output      stk_stat_t          stat,
    output      logic [ENTRY_W-1:0] top
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [ENTRY_W-1:0] mem [STACK_DEPTH];

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [ENTRY_W-1:0] top_reg;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               load_pend_reg;
    logic               load_pend_next;
    logic [CW-1:0]      wr_cnt;
    logic [CW-1:0]      rd_cnt;
    logic               do_push;
    logic               do_pop;
    logic               do_write;
    logic               do_read;

    assign do_push  = cmd.push && !cmd.clear;
    assign do_pop   = cmd.pop && !cmd.clear;
    assign wr_cnt   = count_reg - CW'(1);
    assign rd_cnt   = count_reg - CW'(2);
    assign do_write = do_push && (count_reg != '0);
    assign do_read  = do_pop && (count_reg > CW'(1));

    always_comb
    begin
        count_next     = count_reg;
        load_pend_next = do_read;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (do_push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            load_pend_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            load_pend_reg <= load_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[wr_cnt[AW-1:0]] <= top_reg;
        end
        if (do_read)
        begin
            rd_data_reg <= mem[rd_cnt[AW-1:0]];
        end
    end

    // after a pop, the new top is read from RAM into rd_data_reg, then copied into top_reg
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            top_reg <= push_entry;
        end
        else if (load_pend_reg)
        begin
            top_reg <= rd_data_reg;
        end
    end

    assign top         = top_reg;
    assign stat.empty  = (count_reg == '0);
    assign stat.single = (count_reg == CW'(1));
    assign stat.full   = (count_reg == CW'(STACK_DEPTH));

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        do_push |-> !stat.full)
        else $error("push on full tag stack");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop |-> !stat.empty)
        else $error("pop on empty tag stack");

    a_load_vs_push: assert property (@(posedge clk) disable iff (!rst_n)
        load_pend_reg |-> !do_push)
        else $error("push collides with top reload");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("tag stack count out of range");

endmodule

`default_nettype wire

FILE: src/nmv_parser.sv
// Markup parser state machine: phase, tag name buffer, CDATA matching.
// Uses nmv_pkg; drives the tag stack commands and the per-request verdict.
`default_nettype none

module nmv_parser
    import nmv_pkg::*;
#(
    parameter int NAME_MAX = NMV_NAME_MAX,
    parameter int NB_W     = NAME_MAX * 5,
    parameter int LEN_W    = $clog2(NAME_MAX + 1),
    parameter int ENTRY_W  = NB_W + LEN_W
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               take,
    input  wire logic [7:0]         symbol,
    input  wire logic               final_symbol,
    input  wire stk_stat_t          stat,
    input  wire logic [ENTRY_W-1:0] top,
    output      stk_cmd_t           cmd,
    output      logic [ENTRY_W-1:0] push_entry,
    output      logic               verdict
);

    localparam logic [3:0] PH_FIRST      = 4'd0;
    localparam logic [3:0] PH_CONTENT    = 4'd1;
    localparam logic [3:0] PH_AFTER_LT   = 4'd2;
    localparam logic [3:0] PH_START_NAME = 4'd3;
    localparam logic [3:0] PH_END_NAME   = 4'd4;
    localparam logic [3:0] PH_CDATA_OPEN = 4'd5;
    localparam logic [3:0] PH_CDATA_BODY = 4'd6;
    localparam logic [3:0] PH_DONE       = 4'd7;
    localparam logic [3:0] PH_ERROR      = 4'd8;

    logic [3:0]       phase_reg;
    logic [3:0]       phase_next;
    logic [NB_W-1:0]  nbuf_reg;
    logic [NB_W-1:0]  nbuf_next;
    logic [LEN_W-1:0] nlen_reg;
    logic [LEN_W-1:0] nlen_next;
    logic             root_reg;
    logic             root_next;
    logic [2:0]       cmatch_reg;
    logic [2:0]       cmatch_next;
    logic [1:0]       brun_reg;
    logic [1:0]       brun_next;

    logic             is_letter;
    logic [4:0]       letter;
    logic             closing;
    logic             name_full;
    logic [ENTRY_W-1:0] cur_entry;

    assign is_letter  = (symbol >= CH_A) && (symbol <= CH_Z);
    assign letter     = 5'(symbol - CH_A);
    assign closing    = (phase_reg == PH_END_NAME);
    assign name_full  = (nlen_reg >= LEN_W'(NAME_MAX));
    assign cur_entry  = {nbuf_reg, nlen_reg};
    assign push_entry = cur_entry;

    always_comb
    begin
        phase_next  = phase_reg;
        nbuf_next   = nbuf_reg;
        nlen_next   = nlen_reg;
        root_next   = root_reg;
        cmatch_next = cmatch_reg;
        brun_next   = brun_reg;
        cmd         = '0;
        if (take)
        begin
            unique case (phase_reg) inside
                PH_FIRST:
                begin
                    phase_next = (symbol == CH_LT) ? PH_AFTER_LT : PH_ERROR;
                end
                PH_CONTENT:
                begin
                    if (symbol == CH_LT)
                    begin
                        phase_next = PH_AFTER_LT;
                    end
                end
                PH_AFTER_LT:
                begin
                    nbuf_next = '0;
                    nlen_next = '0;
                    if (symbol == CH_SLASH)
                    begin
                        phase_next = PH_END_NAME;
                    end
                    else if (symbol == CH_BANG && !stat.empty)
                    begin
                        cmatch_next = '0;
                        phase_next  = PH_CDATA_OPEN;
                    end
                    else if (is_letter)
                    begin
                        nbuf_next  = NB_W'(letter);
                        nlen_next  = LEN_W'(1);
                        phase_next = PH_START_NAME;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                    end
                end
                PH_START_NAME, PH_END_NAME:
                begin
                    if (symbol == CH_GT)
                    begin
                        if (nlen_reg == '0)
                        begin
                            phase_next = PH_ERROR;
                        end
                        else if (closing)
                        begin
                            if (stat.empty || top != cur_entry)
                            begin
                                phase_next = PH_ERROR;
                            end
                            else
                            begin
                                cmd.pop    = 1'b1;
                                phase_next = stat.single ? PH_DONE : PH_CONTENT;
                            end
                        end
                        else if (stat.full)
                        begin
                            phase_next = PH_ERROR;
                        end
                        else
                        begin
                            cmd.push   = 1'b1;
                            root_next  = 1'b1;
                            phase_next = PH_CONTENT;
                        end
                    end
                    else if (is_letter && !name_full)
                    begin
                        nbuf_next = (nbuf_reg << 5) | NB_W'(letter);
                        nlen_next = nlen_reg + LEN_W'(1);
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                    end
                end
                PH_CDATA_OPEN:
                begin
                    if (cmatch_reg >= CDATA_LEN || symbol != cdata_char(cmatch_reg))
                    begin
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        cmatch_next = cmatch_reg + 3'd1;
                        if (cmatch_next == CDATA_LEN)
                        begin
                            brun_next  = '0;
                            phase_next = PH_CDATA_BODY;
                        end
                    end
                end
                PH_CDATA_BODY:
                begin
                    if (symbol == CH_RBRACK)
                    begin
                        if (brun_reg < 2'd2)
                        begin
                            brun_next = brun_reg + 2'd1;
                        end
                    end
                    else if (symbol == CH_GT && brun_reg == 2'd2)
                    begin
                        brun_next  = '0;
                        phase_next = PH_CONTENT;
                    end
                    else
                    begin
                        brun_next = '0;
                    end
                end
                default:
                begin
                    phase_next = PH_ERROR;
                end
            endcase
        end
        cmd.clear = take && final_symbol;
    end

    assign verdict = (phase_next == PH_DONE) && root_next && (symbol == CH_GT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FIRST;
            nbuf_reg   <= '0;
            nlen_reg   <= '0;
            root_reg   <= 1'b0;
            cmatch_reg <= '0;
            brun_reg   <= '0;
        end
        else if (take && final_symbol)
        begin
            phase_reg  <= PH_FIRST;
            nbuf_reg   <= '0;
            nlen_reg   <= '0;
            root_reg   <= 1'b0;
            cmatch_reg <= '0;
            brun_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            nbuf_reg   <= nbuf_next;
            nlen_reg   <= nlen_next;
            root_reg   <= root_next;
            cmatch_reg <= cmatch_next;
            brun_reg   <= brun_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/nmv_verdict_q.sv
// Two-entry verdict queue between the parser and the result channel.
// No package dependency.
`default_nettype none

module nmv_verdict_q
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire logic push_data,
    input  wire logic pop,
    output      logic valid,
    output      logic full,
    output      logic data
);

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       d0_reg;
    logic       d1_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            d0_reg <= (push && cnt_reg == 2'd1) ? push_data : d1_reg;
            if (push)
            begin
                d1_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
            begin
                d0_reg <= push_data;
            end
            else
            begin
                d1_reg <= push_data;
            end
        end
    end

    assign valid = (cnt_reg != 2'd0);
    assign full  = (cnt_reg == 2'd2);
    assign data  = d0_reg && (cnt_reg != 2'd0);

endmodule

`default_nettype wire

FILE: src/nested_tag_markup_validator.sv
// Nested tag markup validator, top level.
// Uses nmv_pkg, nmv_parser, nmv_tag_stack and nmv_verdict_q.
//
// Usage:
//   Symbol channel (symbol_valid / symbol_stall, symbol, final_symbol) takes one
//   byte of markup text per request. final_symbol marks the last byte of a text.
//   Verdict channel (verdict_valid / verdict_stall, text_valid) gives one
//   request per text: 1 when the text is one well formed root element.
//   Throughput: one byte per cycle while symbol_stall is low. Each byte updates
//   the parse phase, and a push loads the cached stack top directly; the tag
//   stack RAM is read on a pop into a data register, which then refills the
//   top register before any later byte can need it.
//   The verdict is written into the queue when the final byte is taken.
//   Verdicts pass through a two-entry queue. symbol_stall rises only when two
//   verdicts are waiting behind a stalled receiver; bytes keep flowing while
//   a single verdict waits.
//   Reset (rst_n low, asynchronous) empties the stack and queue and expects
//   the first byte of a new text. After each final byte all parse state
//   returns to its reset values.
`default_nettype none

module nested_tag_markup_validator
    import nmv_pkg::*;
#(
    parameter int NAME_MAX    = NMV_NAME_MAX,
    parameter int STACK_DEPTH = NMV_STACK_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       symbol_valid,
    output      logic       symbol_stall,
    input  wire logic [7:0] symbol,
    input  wire logic       final_symbol,
    output      logic       verdict_valid,
    input  wire logic       verdict_stall,
    output      logic       text_valid
);

    localparam int NB_W    = NAME_MAX * 5;
    localparam int LEN_W   = $clog2(NAME_MAX + 1);
    localparam int ENTRY_W = NB_W + LEN_W;

    stk_cmd_t           cmd;
    stk_stat_t          stat;
    logic [ENTRY_W-1:0] top;
    logic [ENTRY_W-1:0] push_entry;
    logic               take;
    logic               verdict;
    logic               q_full;

    assign take         = symbol_valid && !symbol_stall;
    assign symbol_stall = q_full;

    nmv_parser #(
        .NAME_MAX (NAME_MAX),
        .NB_W     (NB_W),
        .LEN_W    (LEN_W),
        .ENTRY_W  (ENTRY_W)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .symbol       (symbol),
        .final_symbol (final_symbol),
        .stat         (stat),
        .top          (top),
        .cmd          (cmd),
        .push_entry   (push_entry),
        .verdict      (verdict)
    );

    nmv_tag_stack #(
        .ENTRY_W     (ENTRY_W),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .push_entry (push_entry),
        .stat       (stat),
        .top        (top)
    );

    nmv_verdict_q u_vq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take && final_symbol),
        .push_data (verdict),
        .pop       (verdict_valid && !verdict_stall),
        .valid     (verdict_valid),
        .full      (q_full),
        .data      (text_valid)
    );

endmodule

`default_nettype wire
